FILE: rtl/qdec_pkg.sv
`default_nettype none

package qdec_pkg;

  localparam int unsigned NumEncodersDef = 4;
  localparam int unsigned KindW          = 2;
  localparam int unsigned PinW           = 8;
  localparam int unsigned IdW            = 3;
  localparam int unsigned DeltaW         = 16;
  localparam int unsigned InDataW        = 16;  // pins + id, padded to whole bytes
  localparam int unsigned OutDataW       = 16;

  typedef enum logic [KindW-1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_READ    = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_CAPTURE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_e;

  // indexed by {previous pair, new pair}, A in the high bit of each pair
  localparam step_e StepTable [0:15] = '{
    STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE,
    STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
    STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
    STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE
  };

  localparam logic signed [DeltaW-1:0] DeltaMax = {1'b0, {(DeltaW-1){1'b1}}};
  localparam logic signed [DeltaW-1:0] DeltaMin = {1'b1, {(DeltaW-1){1'b0}}};

endpackage

`default_nettype wire

FILE: rtl/multi_channel_quadrature_decoder.sv
`default_nettype none

// Multi-channel x4 quadrature decoder. Each transaction on the slave stream
// carries a kind in tuser: sample pins (every encoder's A/B pair is compared
// with the pair it saw last and a valid single step adds +1 or -1 to that
// encoder's 16-bit signed count, saturating at 32767 / -32768; a double
// step only updates the stored pair), read-and-clear one count, clear one
// count, or capture a new baseline pair set and clear all counts. Every
// input transaction yields exactly one output transaction, whose tdata is
// the count read (kind read with an id below NUM_ENCODERS) or zero.
// Encoders from 4 up have no pins and always see pair 00. Rate: one
// transaction per cycle sustained when the master side is ready. Path:
// input register, then the per-lane table lookup and saturating add into
// the result register. Each stage holds while its downstream side stalls.
module multi_channel_quadrature_decoder
  import qdec_pkg::*;
#(
  parameter int unsigned NUM_ENCODERS = NumEncodersDef  // 1..8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // slave stream
  input  wire logic                       s_axis_tvalid_i,
  output      logic                       s_axis_tready_o,
  input  wire logic [InDataW-1:0]         s_axis_tdata_i,  // [7:0] pin_levels, [10:8] encoder_id
  input  wire logic [KindW-1:0]           s_axis_tuser_i,  // [1:0] kind
  // master stream
  output      logic                       m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  output      logic signed [OutDataW-1:0] m_axis_tdata_o   // [15:0] delta_value
);

  // input register
  logic              in_valid_q;
  kind_e             in_kind_q;
  logic [PinW-1:0]   in_pins_q;
  logic [IdW-1:0]    in_id_q;

  // per-encoder state
  logic [1:0]               prev_q [NUM_ENCODERS];
  logic [1:0]               prev_d [NUM_ENCODERS];
  logic signed [DeltaW-1:0] acc_q  [NUM_ENCODERS];
  logic signed [DeltaW-1:0] acc_d  [NUM_ENCODERS];

  // result register
  logic                     out_valid_q;
  logic signed [DeltaW-1:0] delta_q;
  logic signed [DeltaW-1:0] delta_d;

  logic advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = delta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_kind_q <= kind_e'(s_axis_tuser_i);
      in_pins_q <= s_axis_tdata_i[PinW-1:0];
      in_id_q   <= s_axis_tdata_i[PinW +: IdW];
    end
  end

  // per-lane decode
  always_comb begin
    logic [1:0] now_pair;
    step_e      step;
    delta_d = '0;
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      // lanes past the pin field shift out to 00
      now_pair  = 2'(in_pins_q >> (2 * i));
      step      = StepTable[{prev_q[i], now_pair}];
      prev_d[i] = prev_q[i];
      acc_d[i]  = acc_q[i];
      unique case (in_kind_q)
        KIND_SAMPLE: begin
          prev_d[i] = now_pair;
          if (step == STEP_UP && acc_q[i] != DeltaMax) begin
            acc_d[i] = acc_q[i] + DeltaW'(1);
          end else if (step == STEP_DOWN && acc_q[i] != DeltaMin) begin
            acc_d[i] = acc_q[i] - DeltaW'(1);
          end
        end
        KIND_READ: begin
          if (in_id_q == IdW'(i)) begin
            delta_d  = acc_q[i];
            acc_d[i] = '0;
          end
        end
        KIND_CLEAR: begin
          if (in_id_q == IdW'(i)) begin
            acc_d[i] = '0;
          end
        end
        KIND_CAPTURE: begin
          prev_d[i] = now_pair;
          acc_d[i]  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        prev_q[i] <= '0;
        acc_q[i]  <= '0;
      end
    end else if (advance) begin
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        prev_q[i] <= prev_d[i];
        acc_q[i]  <= acc_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      delta_q <= delta_d;
    end
  end

`ifndef SYNTHESIS
  a_non_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_kind_q != KIND_READ |=> m_axis_tdata_o == '0)
    else $error("non-read transaction produced nonzero delta");

  a_capture_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_kind_q == KIND_CAPTURE |=> acc_q[0] == '0)
    else $error("capture left a count uncleared");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input register dropped a stalled transaction");

  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid_o)
    else $error("processed transaction produced no result");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/multi_channel_quadrature_decoder_tb.sv
module multi_channel_quadrature_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qdec_pkg::*;

  localparam int unsigned NumEnc = NumEncodersDef;
  // Far above the slowest correct run: ~2k transactions, each side idling.
  localparam int unsigned CycleLimit = 40000;
  localparam int unsigned RunSteps = 200;
  localparam int unsigned RandItems = 1700;

  // Per-lane motion requested from the stimulus side.
  typedef enum int {
    MOVE_HOLD,
    MOVE_FWD,
    MOVE_BACK,
    MOVE_SKIP
  } move_e;

  // ---------------------------------------------------------------------------
  // Count tracker: keeps its own copy of every lane's last pair and count,
  // and holds the counts expected on the master stream in arrival order.
  // ---------------------------------------------------------------------------
  class quad_count_tracker;
    logic [1:0]         last_pair [NumEnc];
    logic signed [15:0] lane_count [NumEnc];
    logic signed [15:0] count_fifo [$];
    int unsigned        errors;

    function new();
      for (int i = 0; i < NumEnc; i++) begin
        last_pair[i]  = 2'b00;
        lane_count[i] = '0;
      end
      errors = 0;
    endfunction

    // Position of a pair along the gray cycle 00 -> 10 -> 11 -> 01.
    function int gray_pos(logic [1:0] p);
      case (p)
        2'b00:   gray_pos = 0;
        2'b10:   gray_pos = 1;
        2'b11:   gray_pos = 2;
        default: gray_pos = 3;
      endcase
    endfunction

    function logic [1:0] pins_of_lane(logic [7:0] pins, int unsigned lane);
      if (lane < 4) pins_of_lane = pins[2*lane +: 2];
      else pins_of_lane = 2'b00;  // lanes from 4 up have no pins
    endfunction

    function int unsigned pending();
      pending = count_fifo.size();
    endfunction

    task report(string what, logic signed [15:0] got, logic signed [15:0] want);
      $display("[%0t] mismatch: %s, got %0d, expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    // Accepted input transaction: update the lanes and queue the expected count.
    function void note_input(kind_e kind, logic [7:0] pins, logic [2:0] id);
      logic signed [15:0] answer;
      logic [1:0]         now;
      int                 quarters;
      int                 sum;
      answer = '0;
      case (kind)
        KIND_SAMPLE: begin
          for (int unsigned i = 0; i < NumEnc; i++) begin
            now = pins_of_lane(pins, i);
            if (now != last_pair[i]) begin
              quarters = (gray_pos(now) - gray_pos(last_pair[i]) + 4) % 4;
              // one quarter forward counts up, one back counts down,
              // two quarters is a lost step and only moves the baseline
              if (quarters != 2) begin
                sum = int'(lane_count[i]) + ((quarters == 1) ? 1 : -1);
                if (sum > 32767) sum = 32767;
                if (sum < -32768) sum = -32768;
                lane_count[i] = sum[15:0];
              end
              last_pair[i] = now;
            end
          end
        end
        KIND_READ: begin
          if (id < NumEnc) begin
            answer = lane_count[id];
            lane_count[id] = '0;
          end
        end
        KIND_CLEAR: begin
          if (id < NumEnc) lane_count[id] = '0;
        end
        default: begin
          for (int unsigned i = 0; i < NumEnc; i++) begin
            last_pair[i]  = pins_of_lane(pins, i);
            lane_count[i] = '0;
          end
        end
      endcase
      count_fifo.push_back(answer);
    endfunction

    task check_result(logic signed [15:0] got);
      logic signed [15:0] want;
      if (count_fifo.size() == 0) begin
        report("output transaction with nothing pending", got, '0);
      end else begin
        want = count_fifo.pop_front();
        if (got !== want) report("delta_value", got, want);
      end
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       s_axis_tvalid_i = 1'b0;
  logic                       s_axis_tready_o;
  logic [InDataW-1:0]         s_axis_tdata_i = '0;  // [7:0] pin_levels, [10:8] encoder_id
  logic [KindW-1:0]           s_axis_tuser_i = '0;  // [1:0] kind
  logic                       m_axis_tvalid_o;
  logic                       m_axis_tready_i = 1'b0;
  logic signed [OutDataW-1:0] m_axis_tdata_o;       // [15:0] delta_value

  always #10 clk_i = ~clk_i;

  multi_channel_quadrature_decoder #(
    .NUM_ENCODERS(NumEnc)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  quad_count_tracker counts = new();

  // When set, neither side idles: back-to-back transactions at full rate.
  bit          no_idle = 1'b0;
  logic [7:0]  pin_state = 8'h00;  // last pin levels sent on sample/capture
  int unsigned cycles = 0;

  // ---------------------------------------------------------------------------
  // Receiver: random backpressure, changed on the falling edge only.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (no_idle) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= ($urandom_range(0, 99) >= 28);
  end

  // ---------------------------------------------------------------------------
  // Output monitor and watchdog, both on the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) counts.check_result(m_axis_tdata_o);
    if (cycles > CycleLimit) begin
      $display("[%0t] watchdog expired with %0d transactions pending",
               $realtime, counts.pending());
      $display("multi_channel_quadrature_decoder regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------

  // One slave transaction. Random idle cycles go in front of it; tvalid only
  // drops when an idle cycle really happens, so back-to-back transactions
  // never see a low/high pair of assignments in one time step.
  task automatic send(kind_e kind, logic [7:0] pins, logic [2:0] id);
    @(negedge clk_i);
    while (!no_idle && ($urandom_range(0, 99) < 28)) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'b00000, id, pins};
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    counts.note_input(kind, pins, id);
    if (kind == KIND_SAMPLE || kind == KIND_CAPTURE) pin_state = pins;
  endtask

  // Stop sending until every pending count has come back.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (counts.pending() != 0) @(posedge clk_i);
  endtask

  // Next pair of one lane for the requested motion.
  function automatic logic [1:0] move_pair(logic [1:0] p, move_e m);
    case (m)
      MOVE_FWD:  move_pair = (p == 2'b00) ? 2'b10 : (p == 2'b10) ? 2'b11 :
                             (p == 2'b11) ? 2'b01 : 2'b00;
      MOVE_BACK: move_pair = (p == 2'b00) ? 2'b01 : (p == 2'b01) ? 2'b11 :
                             (p == 2'b11) ? 2'b10 : 2'b00;
      MOVE_SKIP: move_pair = p ^ 2'b11;
      default:   move_pair = p;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    int unsigned mv;
    logic [7:0]  pins;
    move_e       lane_move;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single steps both ways, unchanged pins, lost steps, reads and
    // clears in and out of range, baseline captures at both extremes.
    send(KIND_CAPTURE, 8'h00, 3'd0);
    send(KIND_SAMPLE,  8'hAA, 3'd0);  // every lane +1
    send(KIND_SAMPLE,  8'hAA, 3'd0);  // unchanged pins
    send(KIND_SAMPLE,  8'hFF, 3'd0);  // every lane +1 again
    send(KIND_SAMPLE,  8'h00, 3'd0);  // both phases flip: baseline only
    send(KIND_SAMPLE,  8'h55, 3'd0);  // every lane -1
    send(KIND_READ,    8'h00, 3'd0);
    send(KIND_READ,    8'hFF, 3'd3);
    send(KIND_READ,    8'h00, 3'd4);  // id out of range reads zero
    send(KIND_READ,    8'h00, 3'd7);
    send(KIND_CLEAR,   8'h00, 3'd1);
    send(KIND_CLEAR,   8'h00, 3'd5);  // ignored
    send(KIND_READ,    8'h00, 3'd1);
    send(KIND_READ,    8'h00, 3'd2);
    send(KIND_SAMPLE,  8'h9C, 3'd6);  // +1, -1, hold and lost step per lane
    send(KIND_READ,    8'h00, 3'd0);
    send(KIND_READ,    8'h00, 3'd1);
    send(KIND_CAPTURE, 8'hFF, 3'd0);
    send(KIND_READ,    8'h00, 3'd3);
    send(KIND_SAMPLE,  8'hFE, 3'd0);  // lane 0 steps back from 11
    send(KIND_READ,    8'h00, 3'd0);
    send(KIND_READ,    8'h00, 3'd2);

    // Long runs: lanes 0 and 1 forward, lanes 2 and 3 backward; then a step
    // the other way and reads of every lane.
    send(KIND_CAPTURE, 8'h00, 3'd0);
    for (int unsigned k = 0; k < RunSteps; k++) begin
      pins = {move_pair(pin_state[7:6], MOVE_BACK), move_pair(pin_state[5:4], MOVE_BACK),
              move_pair(pin_state[3:2], MOVE_FWD),  move_pair(pin_state[1:0], MOVE_FWD)};
      send(KIND_SAMPLE, pins, 3'd0);
    end
    send(KIND_READ, 8'h00, 3'd0);
    send(KIND_READ, 8'h00, 3'd2);
    pins = {move_pair(pin_state[7:6], MOVE_FWD), move_pair(pin_state[5:4], MOVE_FWD),
            move_pair(pin_state[3:2], MOVE_BACK), move_pair(pin_state[1:0], MOVE_BACK)};
    send(KIND_SAMPLE, pins, 3'd0);
    for (int unsigned i = 0; i < NumEnc; i++) send(KIND_READ, 8'h00, i[2:0]);

    // Random: mostly legal encoder motion with random reads and clears,
    // a few captures and raw pin noise.
    for (int unsigned n = 0; n < RandItems; n++) begin
      no_idle = (n >= 900 && n < 1250);
      if (n == 1500) drain();
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        pins = pin_state;
        for (int unsigned i = 0; i < 4; i++) begin
          mv = $urandom_range(0, 9);
          lane_move = (mv < 3) ? MOVE_HOLD : (mv < 6) ? MOVE_FWD :
                      (mv < 9) ? MOVE_BACK : MOVE_SKIP;
          pins[2*i +: 2] = move_pair(pin_state[2*i +: 2], lane_move);
        end
        send(KIND_SAMPLE, pins, 3'($urandom_range(0, 7)));
      end else if (pick < 83) begin
        send(KIND_READ, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
      end else if (pick < 90) begin
        send(KIND_CLEAR, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
      end else if (pick < 95) begin
        send(KIND_CAPTURE, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
      end else begin
        send(KIND_SAMPLE, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
      end
    end
    no_idle = 1'b0;

    // Wrap up: let every pending count arrive, then a few more cycles for
    // anything stray out of the two-stage pipeline.
    drain();
    repeat (8) @(posedge clk_i);
    if (counts.errors == 0 && counts.pending() == 0) begin
      $display("multi_channel_quadrature_decoder regression: pass");
    end else begin
      $display("multi_channel_quadrature_decoder regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/qdec_pkg.sv
rtl/multi_channel_quadrature_decoder.sv
tb/sv/multi_channel_quadrature_decoder_tb.sv
